/* rtl/swm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swm_pkg
// shared constants and types of the sliding window median filter
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int WINDOW_MAX  = 64;
   localparam int SAMPLE_BITS = 32;
   localparam int IDX_BITS    = $clog2(WINDOW_MAX);
   localparam int CNT_BITS    = $clog2(WINDOW_MAX + 1);
   localparam int AGE_BITS    = IDX_BITS;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   // register index carried by paddr[2]
   localparam logic REG_WINDOW_SIZE = 1'b0;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [AGE_BITS-1:0]           age_type;
   typedef logic [CNT_BITS-1:0]           count_type;

   // what each cell shows its neighbors
   typedef struct packed {
      sample_type value;  // held key
      age_type    age;    // samples arrived after this one
      logic       le;     // held key <= new key
      logic       rm;     // eviction shifts this slot from the right
      logic       lb;     // slot after eviction is <= new key
   } link_type;

endpackage

`default_nettype wire

/* rtl/swm_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swm_cell
// one slot of the sorted window: removes the evicted key and inserts the new
// key using only its own compares and those of its two neighbors
// ----------------------------------------------------------------------------
module swm_cell
   import swm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       load,
   input  wire sample_type key,
   input  wire sample_type evict_key,
   input  wire logic       full,
   input  wire logic       valid,
   input  wire link_type   left,
   input  wire link_type   right,
   output link_type        link
);

   sample_type value_ff, value_in;
   age_type    age_ff, age_in;
   sample_type b_value, bl_value;
   age_type    b_age, bl_age;

   always_comb begin
      link.value = value_ff;
      link.age   = age_ff;
      link.le    = valid && (value_ff <= key);
      link.rm    = full && (!valid || !(value_ff < evict_key));
      link.lb    = link.rm ? right.le : link.le;
   end

   // slot content after eviction, here and one slot to the left
   always_comb begin
      b_value  = link.rm ? right.value : value_ff;
      b_age    = link.rm ? right.age : age_ff;
      bl_value = left.rm ? value_ff : left.value;
      bl_age   = left.rm ? age_ff : left.age;
   end

   always_comb begin
      if (link.lb) begin
         value_in = b_value;
         age_in   = b_age + age_type'(1);
      end else if (left.lb) begin
         value_in = key;
         age_in   = '0;
      end else begin
         value_in = bl_value;
         age_in   = bl_age + age_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/sliding_window_median.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_median
// running lower median over the last window_size signed samples
// ----------------------------------------------------------------------------
// the median of an accepted sample is registered and appears on rsp_* in the next cycle
// throughput: 1 sample per cycle while rsp_* is not stalled; the cell row inserts and evicts in one step
// a sample taken while fewer than window_size - 1 samples are held gives no result
// synchronous active-high reset: window_size = 1, window empty, no result held
// a write to window_size empties the window and filling starts over
// ----------------------------------------------------------------------------
module sliding_window_median
   import swm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // input stream
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [31:0]       req_tdata,   // [31:0] sample
   // result stream
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [31:0]            rsp_tdata,   // [31:0] median
   // register port
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0]      csr_prdata,
   output logic                   csr_pready
);

   localparam link_type LEFT_EDGE  = '{value: '0, age: '0, le: 1'b1, rm: 1'b0, lb: 1'b1};
   localparam link_type RIGHT_EDGE = '{value: '0, age: '0, le: 1'b0, rm: 1'b1, lb: 1'b0};

   logic [6:0]     window_size_ff, window_size_in;
   count_type      count_ff, count_in;
   logic           rsp_valid_ff, rsp_valid_in;
   sample_type     rsp_data_ff, rsp_data_in;
   sample_type     evict_ff, evict_in;

   logic           csr_write;
   logic           accept;
   count_type      k_eff;
   count_type      k_minus1;
   logic [IDX_BITS-1:0] mid;
   age_type        next_evict_age;
   logic           full;
   sample_type     key;
   sample_type     aged_value;
   logic [WINDOW_MAX-1:0] valid;
   link_type       link [WINDOW_MAX];

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_WINDOW_SIZE);

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_WINDOW_SIZE) begin
         csr_prdata = CSR_DW'(window_size_ff);
      end
   end

   // size zero acts as one, oversize saturates
   always_comb begin
      if (window_size_ff == 7'd0) begin
         k_eff = count_type'(1);
      end else if (window_size_ff > 7'(WINDOW_MAX)) begin
         k_eff = count_type'(WINDOW_MAX);
      end else begin
         k_eff = count_type'(window_size_ff);
      end
   end

   assign k_minus1       = k_eff - count_type'(1);
   assign mid            = k_minus1[IDX_BITS:1];
   assign next_evict_age = age_type'(k_eff - count_type'(3));
   assign full           = (count_ff == k_minus1);

   // ---------------------------------------------------------------- stream
   assign key        = sample_type'(req_tdata);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 32'(rsp_data_ff);

   // ---------------------------------------------------------------- cell row
   for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
      assign valid[j] = (count_type'(j) < count_ff);

      if (j == 0 && WINDOW_MAX == 1) begin : g_only
         swm_cell u_cell (
            .clock(clock), .load(accept), .key(key), .evict_key(evict_ff),
            .full(full), .valid(valid[j]), .left(LEFT_EDGE), .right(RIGHT_EDGE),
            .link(link[j])
         );
      end else if (j == 0) begin : g_first
         swm_cell u_cell (
            .clock(clock), .load(accept), .key(key), .evict_key(evict_ff),
            .full(full), .valid(valid[j]), .left(LEFT_EDGE), .right(link[j+1]),
            .link(link[j])
         );
      end else if (j == WINDOW_MAX - 1) begin : g_last
         swm_cell u_cell (
            .clock(clock), .load(accept), .key(key), .evict_key(evict_ff),
            .full(full), .valid(valid[j]), .left(link[j-1]), .right(RIGHT_EDGE),
            .link(link[j])
         );
      end else begin : g_mid
         swm_cell u_cell (
            .clock(clock), .load(accept), .key(key), .evict_key(evict_ff),
            .full(full), .valid(valid[j]), .left(link[j-1]), .right(link[j+1]),
            .link(link[j])
         );
      end
   end

   // key that turns oldest at the next transaction: held entry one step short
   // of the eviction age, or the new key itself for a window of two
   always_comb begin
      aged_value = '0;
      for (int j = 0; j < WINDOW_MAX; j++) begin
         if (valid[j] && (link[j].age == next_evict_age)) begin
            aged_value = aged_value | link[j].value;
         end
      end
   end

   assign evict_in = (k_eff == count_type'(2)) ? key : aged_value;

   // median of the window with the new key inserted, before eviction
   always_comb begin
      if (link[mid].le) begin
         rsp_data_in = link[mid].value;
      end else if (mid == '0) begin
         rsp_data_in = key;
      end else if (link[mid - IDX_BITS'(1)].le) begin
         rsp_data_in = key;
      end else begin
         rsp_data_in = link[mid - IDX_BITS'(1)].value;
      end
   end

   // ---------------------------------------------------------------- control
   always_comb begin
      window_size_in = window_size_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         if (full) begin
            rsp_valid_in = 1'b1;
         end else begin
            count_in = count_ff + count_type'(1);
         end
      end
      // a register write empties the window
      if (csr_write) begin
         window_size_in = csr_pwdata[6:0];
         count_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= 7'd1;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         window_size_ff <= window_size_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         evict_ff <= evict_in;
      end
      if (accept && full) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

/* dv/sliding_window_median_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_median_tb
// self-checking bench for the running median filter: samples go in on the
// req stream, a behavioral window model predicts each median, and every
// transaction on the rsp stream is compared against the oldest prediction
// ----------------------------------------------------------------------------
module sliding_window_median_tb;
   import swm_pkg::*;

   localparam int CLOCK_HALF     = 5;
   localparam int RESET_CYCLES   = 8;
   localparam int SETTLE_CYCLES  = 4;     // margin for a sample still inside the block
   localparam int TAIL_CYCLES    = 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   // byte addresses of the register port; paddr[2] is the register index
   localparam logic [CSR_AW-1:0] ADDR_WINDOW_SIZE = 3'd0;
   localparam logic [CSR_AW-1:0] ADDR_UNMAPPED    = 3'd4;

   localparam sample_type SAMPLE_MIN = 32'sh8000_0000;
   localparam sample_type SAMPLE_MAX = 32'sh7FFF_FFFF;

   // dut connections, all driven to known values from time zero
   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata   = '0;    // [31:0] sample
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [31:0]       rsp_tdata;           // [31:0] median
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // window model: samples in arrival order and the same samples kept sorted
   logic [6:0] window_size = 7'd1;
   sample_type window_by_age[$];
   sample_type window_sorted[$];
   sample_type expected_medians[$];
   sample_type last_sample = '0;

   // idling knobs, percent of cycles
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   int error_count  = 0;
   int quiet_cycles = 0;

   sliding_window_median DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // window model
   // ------------------------------------------------------------------------

   // insert a sample; once the window is full give its lower median and drop
   // the oldest sample (any equal copy will do, the values are the same)
   function automatic bit predict_median(input sample_type s, output sample_type med);
      int k;
      int pos;
      sample_type oldest;
      if (window_size == 0)
         k = 1;                       // size zero acts as a window of one
      else if (window_size > WINDOW_MAX)
         k = WINDOW_MAX;              // oversize saturates
      else
         k = window_size;
      pos = 0;
      // equal samples: the new one lands after those already held
      while (pos < window_sorted.size() && window_sorted[pos] <= s)
         pos++;
      window_sorted.insert(pos, s);
      window_by_age = {window_by_age, s};
      med = '0;
      if (window_by_age.size() < k)
         return 1'b0;
      med    = window_sorted[(k - 1) / 2];
      oldest = window_by_age.pop_front();
      for (int i = 0; i < window_sorted.size(); i++) begin
         if (window_sorted[i] == oldest) begin
            window_sorted.delete(i);
            break;
         end
      end
      return 1'b1;
   endfunction

   function automatic sample_type pick_sample();
      int roll;
      roll = $urandom_range(99);
      if (roll < 50)
         pick_sample = $urandom();
      else if (roll < 70)
         pick_sample = sample_type'($urandom_range(15)) - 8;   // crowd of ties
      else if (roll < 85) begin
         case ($urandom_range(3))
            0: pick_sample = SAMPLE_MIN;
            1: pick_sample = SAMPLE_MAX;
            2: pick_sample = '0;
            default: pick_sample = -1;
         endcase
      end else
         pick_sample = last_sample;
      last_sample = pick_sample;
   endfunction

   // ------------------------------------------------------------------------
   // shared drivers; every task starts and ends right after a rising edge
   // ------------------------------------------------------------------------

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("%t: %s", $realtime, msg);
   endtask

   task automatic set_idling(input int send_pct, input int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // one req transaction; tvalid stays high unless the sender goes idle
   task automatic send_sample(input sample_type s);
      sample_type med;
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      if (predict_median(s, med))
         expected_medians = {expected_medians, med};
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // sender quiet until every median is back, then a few cycles for a
   // sample that gives no result to finish inside the block
   task automatic drain_window();
      req_tvalid <= 1'b0;
      while (expected_medians.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write: setup cycle, then access until pready
   task automatic write_csr(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // a write to window_size throws the held window away
      if (addr[2] == REG_WINDOW_SIZE) begin
         window_size = data[6:0];
         window_by_age.delete();
         window_sorted.delete();
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_window(input logic [6:0] w);
      drain_window();
      // upper data bits carry noise, only the low seven are the register
      write_csr(ADDR_WINDOW_SIZE, ($urandom() & 32'hFFFF_FF80) | CSR_DW'(w));
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // both ends of the sample range through a window of three
   task automatic test_extreme_samples();
      set_window(7'd3);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample('0);
      send_sample(-1);
      send_sample(1);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
   endtask

   // even window gives the lower median; runs of equal samples
   task automatic test_even_window_ties();
      set_window(7'd4);
      send_sample(5);
      send_sample(5);
      send_sample(5);
      send_sample(-5);
      send_sample(5);
      send_sample(-5);
      send_sample(-5);
      send_sample(7);
   endtask

   // size zero acts as one: each sample is its own median
   task automatic test_window_zero();
      set_window(7'd0);
      send_sample(42);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
   endtask

   // a write to an unmapped register must neither resize nor empty the window
   task automatic test_unmapped_register();
      set_window(7'd2);
      send_sample(10);
      send_sample(-20);
      drain_window();
      write_csr(ADDR_UNMAPPED, 32'h0000_0009);
      send_sample(30);
      send_sample(-40);
   endtask

   // sender holds off mid-stream until every median has come back
   task automatic test_drain_pause();
      set_idling(38, 38);
      set_window(7'd5);
      for (int i = 0; i < 10; i++)
         send_sample(pick_sample());
      drain_window();
      for (int i = 0; i < 10; i++)
         send_sample(pick_sample());
   endtask

   // phases of random samples under several window sizes and idling patterns
   task automatic test_random_windows();
      logic [6:0] w;
      int         n;
      for (int p = 0; p < 12; p++) begin
         case (p)
            0:  w = 7'd1;
            3:  w = 7'd64;                            // largest legal window
            6:  w = 7'd127;                           // saturates to the largest
            9:  w = 7'($urandom_range(65, 126));
            11: w = 7'd0;
            default: w = 7'($urandom_range(2, 12));
         endcase
         case (p % 4)
            0: set_idling(0, 0);
            1: set_idling(65, 0);
            2: set_idling(0, 65);
            default: set_idling(38, 38);
         endcase
         set_window(w);
         // big windows need a full fill before the first median
         n = (w >= WINDOW_MAX) ? WINDOW_MAX + 30 : 16;
         for (int i = 0; i < n; i++)
            send_sample(pick_sample());
      end
   endtask

   // ------------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------------

   // receiver stalls at the current rate
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // each rsp transaction against the oldest expected median
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_medians.size() == 0)
            note_error($sformatf("unexpected median %0d",
                                 sample_type'(rsp_tdata)));
         else if (sample_type'(rsp_tdata) !== expected_medians[0]) begin
            note_error($sformatf("median mismatch: expected %0d actual %0d",
                                 expected_medians[0], sample_type'(rsp_tdata)));
            void'(expected_medians.pop_front());
         end else
            void'(expected_medians.pop_front());
      end
   end

   // watchdog: cycles in a row with no transaction on any port
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d medians outstanding",
                  expected_medians.size());
         $display("[sliding_window_median] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idling(0, 0);
      test_extreme_samples();
      test_even_window_ties();
      test_window_zero();
      test_unmapped_register();
      test_drain_pause();
      test_random_windows();

      // let the last medians out, then watch for strays
      drain_window();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_medians.size() != 0)
         note_error($sformatf("%0d medians never came", expected_medians.size()));

      if (error_count == 0) begin
         $display("[sliding_window_median] OK");
      end else begin
         $display("[sliding_window_median] ERROR");
      end
      $finish;
   end

endmodule
